// ----- rtl/ptce_pkg.sv -----
// Shared types and constants for the pedal torque and cadence estimator.
// Holds the in/out word structs, register indexes, sequencer states and fixed coefficients.
// No dependencies.
`default_nettype none

package ptce_pkg;

	// field widths
	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned LEVEL_W  = 3;
	localparam int unsigned REG_W    = 16;
	localparam int unsigned CAD_W    = 16;
	localparam int unsigned TORQUE_W = 19;
	localparam int unsigned POWER_W  = 31;
	localparam int unsigned SETP_W   = 32;
	localparam int unsigned FB_W     = 18;
	localparam int unsigned SUM_W    = 16;
	localparam int unsigned QUART_W  = 4;
	localparam int unsigned TCOEF_W  = 12;
	localparam int unsigned PCOEF_W  = 13;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_OFFSET    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ASSIST_LEVEL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PEDAL_TIMEOUT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PUSH_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_PERIOD     = 3'd4;

	// register reset values
	localparam logic [SAMPLE_W-1:0] RST_TORQUE_OFFSET    = 10'd0;
	localparam logic [LEVEL_W-1:0]  RST_ASSIST_LEVEL     = 3'd3;
	localparam logic [REG_W-1:0]    RST_PEDAL_TIMEOUT    = 16'd10000;
	localparam logic [REG_W-1:0]    RST_ZERO_PUSH_PERIOD = 16'd400;
	localparam logic [REG_W-1:0]    RST_CHECK_PERIOD     = 16'd200;

	localparam logic [LEVEL_W-1:0]  LEVEL_MAX = 3'd5;

	// arithmetic constants
	localparam logic [CAD_W-1:0]    CAD_NUM      = 16'd33333;  // 60e6 / (1800 us tick scale)
	localparam logic [TCOEF_W-1:0]  TORQUE_COEF  = 12'd2306;   // 9.0078 in Q8
	localparam logic [PCOEF_W-1:0]  POWER_COEF   = 13'd6863;   // 2*pi/60 in Q16
	localparam logic [SAMPLE_W-1:0] SAMPLE_FLOOR = 10'd20;

	typedef struct packed {
		logic                kind;           // 0 tick, 1 crank pulse
		logic [SAMPLE_W-1:0] torque_sample;
	} in_t;

	typedef struct packed {
		logic                pedaling;
		logic [CAD_W-1:0]    cadence_rpm;
		logic [TORQUE_W-1:0] torque_avg;
		logic [POWER_W-1:0]  power_est;
		logic [SETP_W-1:0]   setpoint;
		logic [FB_W-1:0]     feedback;
		logic                integral_reset;
	} out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENTER_RD,
		ST_ENTER_WR,
		ST_DIV,
		ST_MUL_TORQUE,
		ST_MUL_CT,
		ST_MUL_POWER,
		ST_SETPOINT,
		ST_CHECK,
		ST_EMIT
	} state_t;

	// assist factor in quarters: 0, 0.75, 1, 1.25, 1.5, 2.0
	function automatic logic [QUART_W-1:0] level_quarters(input logic [LEVEL_W-1:0] lvl);
		logic [QUART_W-1:0] q;
		case (lvl)
			3'd1:    q = 4'd3;
			3'd2:    q = 4'd4;
			3'd3:    q = 4'd5;
			3'd4:    q = 4'd6;
			3'd5:    q = 4'd8;
			default: q = 4'd0;
		endcase
		return q;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/pedal_torque_cadence_estimator_top.sv -----
// Pedal torque and cadence estimator, top level: sequencer, sample ring memory, divider.
// Depends on ptce_pkg.
`default_nettype none

// Each input word is a time tick or a crank pulse with a raw torque sample. A tick with no
// pedaling check due gives no result; a tick that runs the check goes through CHECK to EMIT,
// pushing a zero sample into the ring on the way when one is due. A pulse passes ENTER_RD,
// ENTER_WR, the multiply states, SETPOINT, CHECK and EMIT, adding the 16-step restoring divider
// for 33333/period when cadence is computed, and may trigger a zero push too. The torque window
// lives in a WINDOW-entry synchronous RAM (one read, then one write per sample) whose entries
// read as zero until first written, tracked by per-entry valid flops cleared at reset, so no
// clearing pass is needed. Results sit in an output register; input is taken only when the
// sequencer is idle, and a finished result waits in the register while the next word runs.
module pedal_torque_cadence_estimator_top #(
	parameter int unsigned WINDOW      = 36,
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire ptce_pkg::in_t                     in_word,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output ptce_pkg::out_t                         out_word,
	input  wire logic                              cfg_we,
	input  wire logic [ptce_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ptce_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int unsigned POS_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CMP_W     = (COUNT_WIDTH > ptce_pkg::REG_W) ? COUNT_WIDTH
	                                                                    : ptce_pkg::REG_W;
	localparam int unsigned DIV_CNT_W = $clog2(ptce_pkg::CAD_W);
	localparam int unsigned CT_W      = ptce_pkg::CAD_W + ptce_pkg::TORQUE_W;
	localparam int unsigned TFULL_W   = ptce_pkg::SUM_W + ptce_pkg::TCOEF_W;
	localparam int unsigned PFULL_W   = CT_W + ptce_pkg::PCOEF_W;
	localparam int unsigned SFULL_W   = ptce_pkg::POWER_W + ptce_pkg::QUART_W;

	localparam logic [POS_W-1:0]       POS_LAST = POS_W'(WINDOW - 1);
	localparam logic [DIV_CNT_W-1:0]   DIV_LAST = DIV_CNT_W'(ptce_pkg::CAD_W - 1);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};

	// configuration registers
	logic [ptce_pkg::SAMPLE_W-1:0] offset_q;
	logic [ptce_pkg::LEVEL_W-1:0]  level_q;
	logic [ptce_pkg::REG_W-1:0]    timeout_q;
	logic [ptce_pkg::REG_W-1:0]    zpp_q;
	logic [ptce_pkg::REG_W-1:0]    cper_q;

	// architectural state
	ptce_pkg::state_t              state_q, state_d;
	logic [COUNT_WIDTH-1:0]        gap_q, zpc_q, cc_q, last_period_q;
	logic [POS_W-1:0]              ring_pos_q;
	logic [ptce_pkg::SUM_W-1:0]    sum_q;
	logic                          pedal_q;
	logic [ptce_pkg::CAD_W-1:0]    cad_q;
	logic [ptce_pkg::TORQUE_W-1:0] torque_q;
	logic [ptce_pkg::POWER_W-1:0]  power_q;
	logic [ptce_pkg::SETP_W-1:0]   setp_q;
	logic [ptce_pkg::FB_W-1:0]     fb_q;
	logic                          zr_q;
	logic                          from_check_q;
	logic [WINDOW-1:0]             ring_vld_q;

	// scratch registers
	logic [ptce_pkg::SAMPLE_W-1:0] sample_q;
	logic [ptce_pkg::SAMPLE_W-1:0] ring_mem [WINDOW];
	logic [ptce_pkg::SAMPLE_W-1:0] rd_data_s1;
	logic                          rd_vld_s1;
	logic [COUNT_WIDTH-1:0]        div_rem_q;
	logic [ptce_pkg::CAD_W-1:0]    div_quo_q;
	logic [DIV_CNT_W-1:0]          div_cnt_q;
	logic [CT_W-1:0]               prod_q;

	logic                          out_valid_q;
	ptce_pkg::out_t                out_word_q;

	// control
	logic                          acc_in;
	logic                          emit_go;
	logic                          mem_we, mem_re;
	logic                          do_div;
	logic [COUNT_WIDTH-1:0]        gap_inc, zpc_inc, cc_inc;
	logic                          tick_check_due, pulse_check_due;
	logic                          gap_expired, zp_due;

	// datapath
	logic [ptce_pkg::SAMPLE_W-1:0] diff_sample, cond_sample, old_sample;
	logic [ptce_pkg::SUM_W-1:0]    sum_next;
	logic [COUNT_WIDTH:0]          div_shift, div_diff;
	logic                          div_ge;
	logic [COUNT_WIDTH-1:0]        div_rem_next;
	logic [ptce_pkg::CAD_W-1:0]    div_quo_next;
	logic [TFULL_W-1:0]            torque_full;
	logic [ptce_pkg::TORQUE_W:0]   torque_shr;
	logic [ptce_pkg::TORQUE_W-1:0] torque_sat;
	logic [PFULL_W-1:0]            power_full;
	logic [ptce_pkg::POWER_W:0]    power_shr;
	logic [ptce_pkg::POWER_W-1:0]  power_sat;
	logic [SFULL_W-1:0]            setp_full;
	logic [ptce_pkg::SETP_W:0]     setp_shr;
	logic [ptce_pkg::SETP_W-1:0]   setp_sat;

	// saturating counter increments and check compares
	always_comb begin
		gap_inc = (gap_q == CNT_MAX) ? gap_q : gap_q + 1'b1;
		zpc_inc = (zpc_q == CNT_MAX) ? zpc_q : zpc_q + 1'b1;
		cc_inc  = (cc_q == CNT_MAX) ? cc_q : cc_q + 1'b1;
		tick_check_due  = CMP_W'(cc_inc) > CMP_W'(cper_q);
		pulse_check_due = CMP_W'(cc_q) > CMP_W'(cper_q);
		gap_expired     = CMP_W'(gap_q) >= CMP_W'(timeout_q);
		zp_due          = CMP_W'(zpc_q) >= CMP_W'(zpp_q);
	end

	// sample conditioning: offset removal and dead band (10-bit result never exceeds 1023)
	always_comb begin
		diff_sample = (in_word.torque_sample > offset_q) ? in_word.torque_sample - offset_q
		                                                 : '0;
		cond_sample = (diff_sample < ptce_pkg::SAMPLE_FLOOR) ? '0 : diff_sample;
	end

	// ring sum update; unwritten entries read as zero
	always_comb begin
		old_sample = rd_vld_s1 ? rd_data_s1 : '0;
		sum_next   = sum_q - ptce_pkg::SUM_W'(old_sample) + ptce_pkg::SUM_W'(sample_q);
	end

	// one restoring division step
	always_comb begin
		div_shift    = {div_rem_q, div_quo_q[ptce_pkg::CAD_W-1]};
		div_diff     = div_shift - {1'b0, last_period_q};
		div_ge       = div_shift >= {1'b0, last_period_q};
		div_rem_next = div_ge ? div_diff[COUNT_WIDTH-1:0] : div_shift[COUNT_WIDTH-1:0];
		div_quo_next = {div_quo_q[ptce_pkg::CAD_W-2:0], div_ge};
	end

	// derived values with saturation
	always_comb begin
		torque_full = TFULL_W'(sum_q) * TFULL_W'(ptce_pkg::TORQUE_COEF);
		torque_shr  = torque_full[8 +: ptce_pkg::TORQUE_W+1];
		torque_sat  = torque_shr[ptce_pkg::TORQUE_W] ? {ptce_pkg::TORQUE_W{1'b1}}
		                                             : torque_shr[ptce_pkg::TORQUE_W-1:0];
		power_full  = PFULL_W'(prod_q) * PFULL_W'(ptce_pkg::POWER_COEF);
		power_shr   = power_full[16 +: ptce_pkg::POWER_W+1];
		power_sat   = power_shr[ptce_pkg::POWER_W] ? {ptce_pkg::POWER_W{1'b1}}
		                                           : power_shr[ptce_pkg::POWER_W-1:0];
		setp_full   = SFULL_W'(power_q) * SFULL_W'(ptce_pkg::level_quarters(level_q));
		setp_shr    = setp_full[2 +: ptce_pkg::SETP_W+1];
		setp_sat    = setp_shr[ptce_pkg::SETP_W] ? {ptce_pkg::SETP_W{1'b1}}
		                                         : setp_shr[ptce_pkg::SETP_W-1:0];
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptce_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and strobes
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		mem_re   = 1'b0;
		mem_we   = 1'b0;
		emit_go  = 1'b0;
		do_div   = (last_period_q != '0) && pedal_q;
		case (state_q)
			ptce_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_word.kind) begin
						state_d = ptce_pkg::ST_ENTER_RD;
					end else if (tick_check_due) begin
						state_d = ptce_pkg::ST_CHECK;
					end
				end
			end
			ptce_pkg::ST_ENTER_RD: begin
				mem_re  = 1'b1;
				state_d = ptce_pkg::ST_ENTER_WR;
			end
			ptce_pkg::ST_ENTER_WR: begin
				mem_we  = 1'b1;
				state_d = do_div ? ptce_pkg::ST_DIV : ptce_pkg::ST_MUL_TORQUE;
			end
			ptce_pkg::ST_DIV: begin
				if (div_cnt_q == DIV_LAST) begin
					state_d = ptce_pkg::ST_MUL_TORQUE;
				end
			end
			ptce_pkg::ST_MUL_TORQUE: begin
				state_d = ptce_pkg::ST_MUL_CT;
			end
			ptce_pkg::ST_MUL_CT: begin
				state_d = ptce_pkg::ST_MUL_POWER;
			end
			ptce_pkg::ST_MUL_POWER: begin
				state_d = from_check_q ? ptce_pkg::ST_EMIT : ptce_pkg::ST_SETPOINT;
			end
			ptce_pkg::ST_SETPOINT: begin
				state_d = ptce_pkg::ST_CHECK;
			end
			ptce_pkg::ST_CHECK: begin
				state_d = (gap_expired && zp_due) ? ptce_pkg::ST_ENTER_RD : ptce_pkg::ST_EMIT;
			end
			ptce_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					emit_go = 1'b1;
					state_d = ptce_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ptce_pkg::ST_IDLE;
			end
		endcase
	end

	assign acc_in = in_valid && in_ready;

	// configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q      <= ptce_pkg::RST_TORQUE_OFFSET;
			level_q       <= ptce_pkg::RST_ASSIST_LEVEL;
			timeout_q     <= ptce_pkg::RST_PEDAL_TIMEOUT;
			zpp_q         <= ptce_pkg::RST_ZERO_PUSH_PERIOD;
			cper_q        <= ptce_pkg::RST_CHECK_PERIOD;
			gap_q         <= CNT_MAX;
			zpc_q         <= '0;
			cc_q          <= '0;
			last_period_q <= '0;
			ring_pos_q    <= '0;
			sum_q         <= '0;
			pedal_q       <= 1'b0;
			cad_q         <= '0;
			torque_q      <= '0;
			power_q       <= '0;
			setp_q        <= '0;
			fb_q          <= '0;
			zr_q          <= 1'b0;
			from_check_q  <= 1'b0;
			ring_vld_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ptce_pkg::CFG_TORQUE_OFFSET: offset_q <= cfg_data[ptce_pkg::SAMPLE_W-1:0];
					ptce_pkg::CFG_ASSIST_LEVEL: begin
						if (cfg_data[ptce_pkg::LEVEL_W-1:0] <= ptce_pkg::LEVEL_MAX) begin
							level_q <= cfg_data[ptce_pkg::LEVEL_W-1:0];
						end
					end
					ptce_pkg::CFG_PEDAL_TIMEOUT:    timeout_q <= cfg_data;
					ptce_pkg::CFG_ZERO_PUSH_PERIOD: zpp_q     <= cfg_data;
					ptce_pkg::CFG_CHECK_PERIOD:     cper_q    <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ptce_pkg::ST_IDLE: begin
					if (acc_in) begin
						zr_q         <= 1'b0;
						from_check_q <= 1'b0;
						if (in_word.kind) begin
							last_period_q <= gap_q;
							gap_q         <= '0;
						end else begin
							gap_q <= gap_inc;
							zpc_q <= zpc_inc;
							cc_q  <= tick_check_due ? '0 : cc_inc;
						end
					end
				end
				ptce_pkg::ST_ENTER_WR: begin
					sum_q                  <= sum_next;
					ring_vld_q[ring_pos_q] <= 1'b1;
					ring_pos_q             <= (ring_pos_q == POS_LAST) ? '0 : ring_pos_q + 1'b1;
					zr_q                   <= zr_q | (sample_q == '0);
					if (!do_div) begin
						cad_q <= '0;
					end
				end
				ptce_pkg::ST_DIV: begin
					if (div_cnt_q == DIV_LAST) begin
						cad_q <= div_quo_next;
					end
				end
				ptce_pkg::ST_MUL_TORQUE: begin
					torque_q <= pedal_q ? torque_sat : '0;
				end
				ptce_pkg::ST_MUL_POWER: begin
					power_q <= power_sat;
				end
				ptce_pkg::ST_SETPOINT: begin
					setp_q <= setp_sat;
					fb_q   <= torque_q[ptce_pkg::TORQUE_W-1:1];
					if (pulse_check_due) begin
						cc_q <= '0;
					end
				end
				ptce_pkg::ST_CHECK: begin
					if (gap_expired) begin
						pedal_q <= 1'b0;
						if (zp_due) begin
							zpc_q         <= '0;
							last_period_q <= '0;
							from_check_q  <= 1'b1;
						end
					end else begin
						pedal_q <= 1'b1;
						zpc_q   <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// sample ring memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[ring_pos_q] <= sample_q;
		end
		if (mem_re) begin
			rd_data_s1 <= ring_mem[ring_pos_q];
		end
	end

	// scratch: sample holding, divider, partial product
	always_ff @(posedge clk) begin
		case (state_q)
			ptce_pkg::ST_IDLE: begin
				if (acc_in && in_word.kind) begin
					sample_q <= cond_sample;
				end
			end
			ptce_pkg::ST_ENTER_RD: begin
				rd_vld_s1 <= ring_vld_q[ring_pos_q];
			end
			ptce_pkg::ST_ENTER_WR: begin
				div_rem_q <= '0;
				div_quo_q <= ptce_pkg::CAD_NUM;
				div_cnt_q <= '0;
			end
			ptce_pkg::ST_DIV: begin
				div_rem_q <= div_rem_next;
				div_quo_q <= div_quo_next;
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			ptce_pkg::ST_MUL_CT: begin
				prod_q <= CT_W'(cad_q) * CT_W'(torque_q);
			end
			ptce_pkg::ST_CHECK: begin
				sample_q <= '0;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_word_q.pedaling       <= pedal_q;
			out_word_q.cadence_rpm    <= cad_q;
			out_word_q.torque_avg     <= torque_q;
			out_word_q.power_est      <= power_q;
			out_word_q.setpoint       <= setp_q;
			out_word_q.feedback       <= fb_q;
			out_word_q.integral_reset <= zr_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// ring pointer stays inside the window
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		ring_pos_q <= POS_LAST)
		else $error("ring pointer out of window");

	// divider only runs on a nonzero period
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptce_pkg::ST_DIV) |-> (last_period_q != '0))
		else $error("divider started with zero period");

	// at rest, nonzero power needs nonzero cadence and torque
	a_power_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptce_pkg::ST_IDLE && power_q != '0) |-> (cad_q != '0 && torque_q != '0))
		else $error("power inconsistent with cadence and torque");

endmodule

`default_nettype wire
